>>> design/rtdd_pkg.sv
// ----------------------------------------------------------------------------
// rtdd_pkg
// Types and constants shared by the tag read deduplicator modules.
// ----------------------------------------------------------------------------
package rtdd_pkg;

   localparam int ID_HIGH_W = 32;
   localparam int ID_LOW_W  = 64;
   localparam int TIME_W    = 32;

   // Request item codes carried on tuser.
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_CLEAR = 1'b1;

   // Configuration register map: register index is paddr[2].
   localparam int   CSR_ADDR_W  = 3;
   localparam logic REG_HOLDOFF = 1'b0;

   localparam logic [TIME_W-1:0] HOLDOFF_RESET = 32'd1000;

   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 8;

   // Request payload, last field in the lowest bits.
   typedef struct packed {
      logic [TIME_W-1:0]    read_time;
      logic [ID_LOW_W-1:0]  tag_id_low;
      logic [ID_HIGH_W-1:0] tag_id_high;
   } req_item_type;

   // One table entry as held in the RAM.
   typedef struct packed {
      logic [TIME_W-1:0]    last_seen;
      logic [ID_LOW_W-1:0]  id_low;
      logic [ID_HIGH_W-1:0] id_high;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Result payload, last field in the lowest bits.
   typedef struct packed {
      logic [5:0] pad;
      logic       table_full;
      logic       report;
   } rsp_item_type;

endpackage

>>> design/rtdd_ram.sv
// ----------------------------------------------------------------------------
// rtdd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rtdd_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rtdd_csr.sv
// ----------------------------------------------------------------------------
// rtdd_csr
// APB-style register block holding the holdoff window.
// ----------------------------------------------------------------------------
module rtdd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rtdd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output logic [rtdd_pkg::TIME_W-1:0]     holdoff
);

   logic [rtdd_pkg::TIME_W-1:0] holdoff_ff;
   logic [rtdd_pkg::TIME_W-1:0] holdoff_in;
   logic                        sel_holdoff;

   assign sel_holdoff = (csr_paddr[2] == rtdd_pkg::REG_HOLDOFF);

   always_comb begin
      holdoff_in = holdoff_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_holdoff) begin
         holdoff_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holdoff_ff <= rtdd_pkg::HOLDOFF_RESET;
      end else begin
         holdoff_ff <= holdoff_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = sel_holdoff ? holdoff_ff : 32'd0;
   assign holdoff    = holdoff_ff;

endmodule

>>> design/rtdd_engine.sv
// ----------------------------------------------------------------------------
// rtdd_engine
// Sequencer that scans the tag table RAM one entry per cycle, refreshes
// matching entries in place and fills the first free slot for a new tag.
// ----------------------------------------------------------------------------
module rtdd_engine #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [rtdd_pkg::TIME_W-1:0]     holdoff,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rtdd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rtdd_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] SCAN_END = CW'(TABLE_ENTRIES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   rtdd_pkg::req_item_type    item_ff, item_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic                      chk_ff, chk_in;
   logic [AW-1:0]             chk_addr_ff, chk_addr_in;
   logic                      matched_ff, matched_in;
   logic                      recent_ff, recent_in;
   logic                      found_free_ff, found_free_in;
   logic [AW-1:0]             free_idx_ff, free_idx_in;
   logic                      res_report_ff, res_report_in;
   logic                      res_full_ff, res_full_in;
   logic [TABLE_ENTRIES-1:0]  valid_ff, valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rtdd_pkg::rsp_item_type    rsp_data_ff, rsp_data_in;

   logic                          accept;
   logic                          rd_en;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic [rtdd_pkg::ENTRY_W-1:0]  rd_data;
   rtdd_pkg::entry_type           wr_entry;
   rtdd_pkg::entry_type           ent;
   logic                          ent_match;
   logic                          ent_recent;
   logic                          ent_free;
   logic [rtdd_pkg::TIME_W-1:0]   age;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign wr_entry.last_seen = item_ff.read_time;
   assign wr_entry.id_low    = item_ff.tag_id_low;
   assign wr_entry.id_high   = item_ff.tag_id_high;

   // An entry that has not been written since reset or a clear reads as zero.
   assign ent = valid_ff[chk_addr_ff] ? rtdd_pkg::entry_type'(rd_data) : '0;
   assign ent_match = (ent.id_high == item_ff.tag_id_high) &&
                      (ent.id_low == item_ff.tag_id_low);
   assign age        = item_ff.read_time - ent.last_seen;
   assign ent_recent = ent_match && (age < holdoff);
   assign ent_free   = (ent.last_seen == '0);

   assign rd_en = (state_ff == ST_SCAN) && (cnt_ff != SCAN_END);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = chk_addr_ff;
      if ((state_ff == ST_SCAN) && chk_ff && ent_match) begin
         wr_en = 1'b1;
      end else if ((state_ff == ST_PLACE) && !matched_ff && found_free_ff) begin
         wr_en   = 1'b1;
         wr_addr = free_idx_ff;
      end
   end

   rtdd_ram #(
      .WIDTH (rtdd_pkg::ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      cnt_in        = cnt_ff;
      chk_in        = 1'b0;
      chk_addr_in   = chk_addr_ff;
      matched_in    = matched_ff;
      recent_in     = recent_ff;
      found_free_in = found_free_ff;
      free_idx_in   = free_idx_ff;
      res_report_in = res_report_ff;
      res_full_in   = res_full_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in = rtdd_pkg::req_item_type'(req_tdata);
               if (req_tuser == rtdd_pkg::MODE_CLEAR) begin
                  valid_in      = '0;
                  res_report_in = 1'b0;
                  res_full_in   = 1'b0;
                  state_in      = ST_DONE;
               end else begin
                  cnt_in        = '0;
                  matched_in    = 1'b0;
                  recent_in     = 1'b0;
                  found_free_in = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               chk_in      = 1'b1;
               chk_addr_in = cnt_ff[AW-1:0];
               cnt_in      = cnt_ff + 1'b1;
            end
            if (chk_ff) begin
               matched_in = matched_ff || ent_match;
               recent_in  = recent_ff || ent_recent;
               if (ent_free && !found_free_ff) begin
                  found_free_in = 1'b1;
                  free_idx_in   = chk_addr_ff;
               end
               // The read data of the last entry is in hand once every
               // address has been issued.
               if (!rd_en) begin
                  state_in = ST_PLACE;
               end
            end
         end
         ST_PLACE: begin
            res_report_in = !recent_ff;
            res_full_in   = !matched_ff && !found_free_ff;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.pad        = '0;
               rsp_data_in.table_full = res_full_ff;
               rsp_data_in.report     = res_report_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_ff       <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_ff       <= chk_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff       <= item_in;
      cnt_ff        <= cnt_in;
      chk_addr_ff   <= chk_addr_in;
      matched_ff    <= matched_in;
      recent_ff     <= recent_in;
      found_free_ff <= found_free_in;
      free_idx_ff   <= free_idx_in;
      res_report_ff <= res_report_in;
      res_full_ff   <= res_full_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> design/rfid_tag_read_deduplicator.sv
// ----------------------------------------------------------------------------
// rfid_tag_read_deduplicator
// Suppresses repeated tag reads inside a holdoff window using a table of
// tag IDs and last-seen times held in RAM.
//
//   Channel   Direction  Signals                       Content
//   req_      in         tvalid/tready/tdata/tuser     tag read or table clear
//   rsp_      out        tvalid/tready/tdata           report and table_full
//   csr_      in         APB psel/penable/pwrite/...   holdoff_ms at address 0
//
// A read item passes through the scan, place and done states before the next
// transfer is accepted: the table RAM read port visits one entry per cycle.
// A clear item goes straight to the done state; it drops all valid bits at once.
// Reset is synchronous; the table is empty right after it, with no sweep.
// A result that is not taken holds the block in its final step only.
// ----------------------------------------------------------------------------
module rfid_tag_read_deduplicator #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [31:0] tag_id_high, [95:32] tag_id_low, [127:96] read_time
   input  logic [rtdd_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] mode
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] report, [1] table_full, [7:2] zero
   output logic [rtdd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rtdd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic [rtdd_pkg::TIME_W-1:0] holdoff;

   rtdd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .holdoff     (holdoff)
   );

   rtdd_engine #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .holdoff    (holdoff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // The block works on one item at a time after a transfer.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while an item was in progress");

   // A tag that finds no slot is unknown, so it can never be suppressed.
   a_full_reports: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |-> rsp_tdata[0])
      else $error("table_full given on a suppressed read");

   // A register write is visible on the read data in the following cycle.
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready &&
       (csr_paddr[2] == rtdd_pkg::REG_HOLDOFF))
      |=> ((csr_paddr[2] != rtdd_pkg::REG_HOLDOFF) || $past(reset) ||
           (csr_prdata == $past(csr_pwdata))))
      else $error("holdoff register readback mismatch");

endmodule

>>> tb/sv/tb_rfid_tag_read_deduplicator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rfid_tag_read_deduplicator
// Drives tag reads and table clears into the deduplicator and checks each
// report and table_full flag against a shadow copy of the tag table. The
// holdoff window is changed through the register port between phases, and
// both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_rfid_tag_read_deduplicator;

   localparam int TABLE_ENTRIES = 16;
   localparam int POOL_SIZE     = 24;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_ITEMS   = 240;

   localparam logic [rtdd_pkg::CSR_ADDR_W-1:0] HOLDOFF_ADDR = {rtdd_pkg::REG_HOLDOFF, 2'b00};
   // Register index 1 has nothing behind it; writes there must be dropped.
   localparam logic [rtdd_pkg::CSR_ADDR_W-1:0] SPARE_ADDR   = 3'b100;

   typedef struct packed {
      logic report;
      logic table_full;
   } verdict_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [rtdd_pkg::REQ_DATA_W-1:0] req_tdata   = '0;
   logic                            req_tuser   = rtdd_pkg::MODE_READ;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [rtdd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [rtdd_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]                     csr_pwdata  = '0;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   // Shadow of the tag table and of the holdoff register.
   logic [rtdd_pkg::ID_HIGH_W-1:0] tbl_id_high [TABLE_ENTRIES];
   logic [rtdd_pkg::ID_LOW_W-1:0]  tbl_id_low  [TABLE_ENTRIES];
   logic [rtdd_pkg::TIME_W-1:0]    tbl_seen    [TABLE_ENTRIES];
   logic [rtdd_pkg::TIME_W-1:0]    holdoff_window = rtdd_pkg::HOLDOFF_RESET;

   verdict_type          verdict_q[$];
   int                   mismatches   = 0;
   int                   stall_cycles = 0;
   logic                 idle_en      = 1'b1;
   logic [95:0]          tag_pool [POOL_SIZE];

   rfid_tag_read_deduplicator #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic void clear_shadow_table();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         tbl_id_high[i] = '0;
         tbl_id_low[i]  = '0;
         tbl_seen[i]    = '0;
      end
   endfunction

   // Updates the shadow table for one item and returns the verdict it gives.
   function automatic verdict_type dedup_lookup(input logic mode,
                                                input rtdd_pkg::req_item_type item);
      verdict_type                 v;
      logic                        recent;
      logic                        matched;
      logic                        placed;
      logic [rtdd_pkg::TIME_W-1:0] age;
      v       = '0;
      recent  = 1'b0;
      matched = 1'b0;
      placed  = 1'b0;
      if (mode == rtdd_pkg::MODE_CLEAR) begin
         clear_shadow_table();
         return v;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         age = item.read_time - tbl_seen[i];
         if (tbl_id_high[i] == item.tag_id_high && tbl_id_low[i] == item.tag_id_low &&
             age < holdoff_window)
            recent = 1'b1;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (tbl_id_high[i] == item.tag_id_high && tbl_id_low[i] == item.tag_id_low) begin
            tbl_seen[i] = item.read_time;
            matched     = 1'b1;
         end
      end
      // A slot counts as free while its time is zero, whatever ID it holds.
      if (!matched) begin
         for (int i = 0; i < TABLE_ENTRIES && !placed; i++) begin
            if (tbl_seen[i] == '0) begin
               tbl_id_high[i] = item.tag_id_high;
               tbl_id_low[i]  = item.tag_id_low;
               tbl_seen[i]    = item.read_time;
               placed         = 1'b1;
            end
         end
         v.table_full = !placed;
      end
      v.report = !recent;
      return v;
   endfunction

   function automatic rtdd_pkg::req_item_type tag_read(input logic [95:0] id,
                                                       input logic [31:0] ms);
      rtdd_pkg::req_item_type item;
      item.tag_id_high = id[95:64];
      item.tag_id_low  = id[63:0];
      item.read_time   = ms;
      return item;
   endfunction

   // Called right after a rising edge; returns at the edge of the transfer.
   task automatic send_item(input logic mode, input rtdd_pkg::req_item_type item);
      if (idle_en && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 25)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= item;
      do @(posedge clock); while (!req_tready);
      verdict_q.push_back(dedup_lookup(mode, item));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [rtdd_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (addr[2] == rtdd_pkg::REG_HOLDOFF)
         holdoff_window = data;
   endtask

   // Receiver side: drops tready at random, about 12 times in a hundred, while idling is enabled.
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !(idle_en && $urandom_range(99) < 12);
   end

   always @(posedge clock) begin
      rtdd_pkg::rsp_item_type got;
      verdict_type            want;
      got = rsp_tdata;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual report %0b table_full %0b",
                     $time, got.report, got.table_full);
            mismatches++;
         end else begin
            want = verdict_q.pop_front();
            if (got.report !== want.report) begin
               $display("%0t: report mismatch: expected %0b, actual %0b",
                        $time, want.report, got.report);
               mismatches++;
            end
            if (got.table_full !== want.table_full) begin
               $display("%0t: table_full mismatch: expected %0b, actual %0b",
                        $time, want.table_full, got.table_full);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // New tags, repeats inside and outside the window, time wrap, the all-zero
   // ID filling every free slot, a full table and reads stored at time zero.
   task automatic test_dedup_basics();
      logic [95:0] tag_a;
      logic [95:0] tag_b;
      logic [95:0] tag_c;
      tag_a = {32'h3000_0001, 64'h0123_4567_89AB_CDEF};
      tag_b = {32'hC5A5_5A5A, 64'hFEDC_BA98_7654_3210};
      tag_c = {32'h0000_0C0C, 64'h0000_0000_0000_C0DE};
      send_item(rtdd_pkg::MODE_READ, tag_read(tag_a, 32'd5));
      send_item(rtdd_pkg::MODE_READ, tag_read(tag_a, 32'd500));
      send_item(rtdd_pkg::MODE_READ, tag_read(tag_a, 32'd1499));
      send_item(rtdd_pkg::MODE_READ, tag_read(tag_a, 32'd2600));
      send_item(rtdd_pkg::MODE_READ, tag_read('1, 32'hFFFF_FFFF));
      send_item(rtdd_pkg::MODE_READ, tag_read('1, 32'd100));
      // The all-zero ID matches every free slot and marks them all used.
      send_item(rtdd_pkg::MODE_READ, tag_read('0, 32'd50));
      send_item(rtdd_pkg::MODE_READ, tag_read(tag_b, 32'd60));
      send_item(rtdd_pkg::MODE_CLEAR, tag_read('1, '1));
      send_item(rtdd_pkg::MODE_READ, tag_read(tag_b, 32'd0));
      send_item(rtdd_pkg::MODE_READ, tag_read(tag_b, 32'd0));
      send_item(rtdd_pkg::MODE_READ, tag_read(tag_c, 32'd7));
      send_item(rtdd_pkg::MODE_READ, tag_read(tag_b, 32'd8));
      send_item(rtdd_pkg::MODE_CLEAR, tag_read('0, '0));
      wait_drained();
   endtask

   // Zero and maximum holdoff, and a write to the unmapped register index.
   task automatic test_holdoff_settings();
      logic [95:0] tag_a;
      tag_a = {32'h3000_0001, 64'h0123_4567_89AB_CDEF};
      csr_write(HOLDOFF_ADDR, 32'd0);
      send_item(rtdd_pkg::MODE_READ, tag_read(tag_a, 32'd10));
      send_item(rtdd_pkg::MODE_READ, tag_read(tag_a, 32'd10));
      wait_drained();
      csr_write(HOLDOFF_ADDR, 32'hFFFF_FFFF);
      send_item(rtdd_pkg::MODE_READ, tag_read(tag_a, 32'd20));
      send_item(rtdd_pkg::MODE_READ, tag_read(tag_a, 32'd19));
      wait_drained();
      csr_write(SPARE_ADDR, 32'd0);
      send_item(rtdd_pkg::MODE_READ, tag_read(tag_a, 32'd19));
      send_item(rtdd_pkg::MODE_CLEAR,
                tag_read({32'h5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5}, 32'h1234_5678));
      wait_drained();
      csr_write(HOLDOFF_ADDR, rtdd_pkg::HOLDOFF_RESET);
   endtask

   // Reads mostly from a small pool of tags so that repeats, a full table
   // and clears all occur; a few reads carry unknown IDs or odd times.
   task automatic run_traffic_phase(input logic [31:0] holdoff, input logic [31:0] start_ms,
                                    input logic quiet, input logic pause_midway);
      logic [31:0]  race_ms;
      logic [31:0]  ms;
      logic [95:0]  id;
      int           pick;
      wait_drained();
      csr_write(HOLDOFF_ADDR, holdoff);
      for (int i = 0; i < POOL_SIZE; i++) begin
         case ($urandom_range(19))
            0:       tag_pool[i] = '0;
            1:       tag_pool[i] = '1;
            default: tag_pool[i] = {$urandom(), $urandom(), $urandom()};
         endcase
      end
      race_ms = start_ms;
      idle_en = !quiet;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (pause_midway && n == PHASE_ITEMS / 2) begin
            wait_drained();
         end
         pick = $urandom_range(99);
         if (pick < 4) begin
            send_item(rtdd_pkg::MODE_CLEAR,
                      tag_read({$urandom(), $urandom(), $urandom()}, $urandom()));
         end else begin
            if (pick < 9)
               id = {$urandom(), $urandom(), $urandom()};
            else if (pick < 55)
               id = tag_pool[$urandom_range(3)];
            else
               id = tag_pool[$urandom_range(POOL_SIZE - 1)];
            race_ms = race_ms + $urandom_range(0, 250);
            pick    = $urandom_range(99);
            if (pick < 3)
               ms = '0;
            else if (pick < 8)
               ms = $urandom();
            else
               ms = race_ms;
            send_item(rtdd_pkg::MODE_READ, tag_read(id, ms));
         end
      end
      idle_en = 1'b1;
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(rtdd_pkg::HOLDOFF_RESET, $urandom_range(1, 100000), 1'b0, 1'b0);
      run_traffic_phase(32'd0, $urandom(), 1'b0, 1'b1);
      run_traffic_phase(32'd1, $urandom(), 1'b1, 1'b0);
      run_traffic_phase(32'hFFFF_FFFF, $urandom(), 1'b0, 1'b0);
      run_traffic_phase($urandom_range(1, 5000), 32'hFFFF_FF00, 1'b0, 1'b0);
      run_traffic_phase($urandom(), $urandom(), 1'b0, 1'b0);
   endtask

   initial begin
      clear_shadow_table();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_dedup_basics();
      test_holdoff_settings();
      test_random_traffic();
      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && verdict_q.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
